/* hw/rtl/video_window_controller_regs_unit_assert.svh */
// Assertion macros for the checker file.
`ifndef VIDEO_WINDOW_CONTROLLER_REGS_UNIT_ASSERT_SVH
`define VIDEO_WINDOW_CONTROLLER_REGS_UNIT_ASSERT_SVH

// Checked only while out of reset.
`define VWC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define VWC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/vwc_pkg.sv */
package vwc_pkg;

    // Function codes (code 0 and code 3 only do the lookups)
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;

    // Port address map
    localparam logic [5:0] WIN_PAGE      = 6'h11;   // 0x110..0x11F index/data ports
    localparam logic [5:0] DOT_PAGE      = 6'h13;   // 0x130..0x13E even
    localparam logic [4:0] PAL_PAGE      = 5'h0A;   // 0x140..0x15F odd
    localparam logic [9:0] ADDR_COLOR    = 10'h120;
    localparam logic [9:0] ADDR_PPRIO    = 10'h122;
    localparam logic [9:0] ADDR_BACK1    = 10'h124;
    localparam logic [9:0] ADDR_BACK2    = 10'h126;
    localparam logic [9:0] ADDR_BACK3    = 10'h128;
    localparam logic [9:0] ADDR_BACK4REV = 10'h12A;
    localparam logic [9:0] ADDR_REV123   = 10'h12C;

    localparam int ITEM_W = 27;

    typedef struct packed {
        logic [2:0] pixel_code;
        logic [3:0] overlap_mask;
        logic [7:0] write_data;
        logic [9:0] port_addr;
        logic [1:0] func;
    } item_t;

    // Register state as seen by the lookup stage
    typedef struct packed {
        logic [15:0][7:0] wregs;
        logic [2:0]       planes0;
        logic [4:1][2:0]  backs;
        logic [4:1]       revs;
        logic [7:0][2:0]  pal;
        logic [2:0]       color_mode;
        logic [2:0]       pprio_mode;
        logic [7:0]       dot_mode;
    } state_t;

    function automatic logic is_index_port(input logic [9:0] a);
        return (a[9:4] == WIN_PAGE) && (a[1:0] == 2'd0);
    endfunction

    function automatic logic is_data_port(input logic [9:0] a);
        return (a[9:4] == WIN_PAGE) && (a[1:0] == 2'd2);
    endfunction

    function automatic logic is_pal_port(input logic [9:0] a);
        return (a[9:5] == PAL_PAGE) && a[0];
    endfunction

    // bit 3 of the address is ignored
    function automatic logic [2:0] pal_slot(input logic [9:0] a);
        return {a[4], a[2:1]};
    endfunction

    // Winner of the overlap mask: highest 2-bit priority, ties to lower window.
    function automatic logic [2:0] win_of(input logic [7:0] prio, input logic [3:0] mask);
        logic [2:0] best;
        logic [1:0] bestp;
        logic [1:0] p;
        best  = 3'd0;
        bestp = 2'd0;
        for (int k = 1; k <= 4; k++) begin
            p = prio[9 - 2*k -: 2];
            if (mask[k-1] && (best == 3'd0 || p > bestp)) begin
                best  = 3'(k);
                bestp = p;
            end
        end
        if (prio == 8'd0) begin
            best = 3'd0;
        end
        return best;
    endfunction

    // Plane priority table: codes 4..7 map to 4 while code[1:0] < mode,
    // otherwise to code[1:0]; codes 0..3 pass.
    function automatic logic [2:0] pprio_color(input logic [2:0] mode, input logic [2:0] c);
        logic [2:0] low;
        low = {1'b0, c[1:0]};
        return (c[2] && (low < mode)) ? 3'd4 : low;
    endfunction

endpackage

/* hw/rtl/vwc_regfile.sv */
module vwc_regfile (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            go,
    input  vwc_pkg::item_t  item,
    output logic [7:0]      read_data,
    output vwc_pkg::state_t state
);
    import vwc_pkg::*;

    logic [3:0]       idx_reg;
    logic [15:0][7:0] wregs_reg;
    logic [2:0]       plane0_reg;
    logic [4:1][2:0]  backs_reg;
    logic [4:1]       revs_reg;
    logic [7:0][2:0]  pal_reg;
    logic [2:0]       color_reg;
    logic [2:0]       pprio_reg;
    logic [7:0]       dot_reg;

    logic       is_wr;
    logic       is_rd;
    logic [9:0] a;
    logic [7:0] d;

    assign a     = item.port_addr;
    assign d     = item.write_data;
    assign is_wr = go && (item.func == FUNC_WRITE);
    assign is_rd = go && (item.func == FUNC_READ);

    always_comb
    begin
        read_data = 8'hFF;
        if (item.func == FUNC_READ)
        begin
            if (is_index_port(a))
                read_data = {4'h0, idx_reg};
            else if (is_data_port(a))
                read_data = wregs_reg[idx_reg];
            else if (is_pal_port(a))
                read_data = {5'd0, pal_reg[pal_slot(a)]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            wregs_reg  <= '0;
            plane0_reg <= '0;
            backs_reg  <= '0;
            revs_reg   <= '0;
            for (int i = 0; i < 8; i++)
                pal_reg[i] <= 3'(i);
            color_reg <= '0;
            pprio_reg <= '0;
            dot_reg   <= '0;
        end
        else if (is_wr)
        begin
            if (is_index_port(a))
                idx_reg <= d[3:0];
            else if (is_data_port(a))
            begin
                wregs_reg[idx_reg] <= d;
                idx_reg            <= idx_reg + 4'd1;
                // background window shows every plane only once register 0 is written zero
                if (idx_reg == 4'd0)
                    plane0_reg <= (d == 8'd0) ? 3'd7 : 3'd0;
            end
            else if (a == ADDR_COLOR)
                color_reg <= d[2:0];
            else if (a == ADDR_PPRIO)
                pprio_reg <= d[2:0];
            else if (a == ADDR_BACK1)
                backs_reg[1] <= d[2:0];
            else if (a == ADDR_BACK2)
                backs_reg[2] <= d[2:0];
            else if (a == ADDR_BACK3)
                backs_reg[3] <= d[2:0];
            else if (a == ADDR_BACK4REV)
            begin
                backs_reg[4] <= d[2:0];
                revs_reg[4]  <= d[0];
            end
            else if (a == ADDR_REV123)
                revs_reg[3:1] <= d[2:0];
            else if ((a[9:4] == DOT_PAGE) && !a[0])
                dot_reg <= d;
            else if (is_pal_port(a))
                pal_reg[pal_slot(a)] <= d[2:0];
        end
        else if (is_rd && is_data_port(a))
        begin
            idx_reg <= idx_reg + 4'd1;
        end
    end

    assign state.wregs      = wregs_reg;
    assign state.planes0    = plane0_reg;
    assign state.backs      = backs_reg;
    assign state.revs       = revs_reg;
    assign state.pal        = pal_reg;
    assign state.color_mode = color_reg;
    assign state.pprio_mode = pprio_reg;
    assign state.dot_mode   = dot_reg;

endmodule

/* hw/rtl/vwc_lookup.sv */
module vwc_lookup (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  vwc_pkg::state_t state,
    input  logic [7:0]      rd_in,
    input  logic [3:0]      mask_in,
    input  logic [2:0]      code_in,
    input  logic            out_ready,
    output logic            out_valid,
    output logic [39:0]     out_data
);
    import vwc_pkg::*;

    logic        valid_reg, valid_next;
    logic [39:0] data_reg, data_next;

    logic [2:0]  wn;
    logic [15:0] start;
    logic [2:0]  planes;
    logic [2:0]  back;
    logic        rev;
    logic [2:0]  pal_c;
    logic [2:0]  pc;

    always_comb
    begin
        wn     = win_of(state.wregs[0], mask_in);
        start  = 16'd0;
        planes = state.planes0;
        back   = 3'd0;
        rev    = 1'b0;
        case (wn)
            3'd1:
            begin
                start  = {state.wregs[2], state.wregs[1]};
                planes = state.wregs[3][2:0];
                back   = state.backs[1];
                rev    = state.revs[1];
            end
            3'd2:
            begin
                start  = {state.wregs[5], state.wregs[4]};
                planes = state.wregs[6][2:0];
                back   = state.backs[2];
                rev    = state.revs[2];
            end
            3'd3:
            begin
                start  = {state.wregs[8], state.wregs[7]};
                planes = state.wregs[9][2:0];
                back   = state.backs[3];
                rev    = state.revs[3];
            end
            3'd4:
            begin
                start  = {state.wregs[11], state.wregs[10]};
                planes = state.wregs[12][2:0];
                back   = state.backs[4];
                rev    = state.revs[4];
            end
            default:
            begin
                start = 16'd0;
            end
        endcase

        pal_c = state.pal[code_in];
        if (state.color_mode[0])
            pc = (code_in != 3'd0) ? 3'd7 : 3'd0;
        else if (state.color_mode[2])
            pc = pprio_color(state.pprio_mode, pal_c);
        else
            pc = pal_c;
    end

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            data_next  = {1'b0, state.dot_mode[2], state.color_mode[0], pc, rev,
                          back, planes, start, wn, rd_in};
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* hw/rtl/video_window_controller_regs_unit.sv */
// Channel   Dir  Handshake               Payload
// s_axis    in   s_tvalid / s_tready     s_tdata[26:0]  (bus access + lookup keys)
// m_axis    out  m_tvalid / m_tready     m_tdata[38:0]  (read data + lookup results)
//
// One item per cycle sustained while the m side is not stalled; from accept to result each
// item passes the input register, register-file access and lookup/result register.
// Lookups see the register state after the item's own bus access.
// rst_n clears the pipeline valid flags and all register-file registers; palette entry i resets to i.
// A stalled m side holds the result; up to two more items are taken meanwhile.
module video_window_controller_regs_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // func[1:0], port_addr[11:2], write_data[19:12], overlap_mask[23:20],
    // pixel_code[26:24], zero pad
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[7:0], window_number[10:8], window_start[26:11],
    // window_planes[29:27], window_back[32:30], window_reverse[33],
    // pixel_color[36:34], mono_mode[37], half_width_mode[38], zero pad
    output logic [39:0] m_tdata
);
    import vwc_pkg::*;

    logic  s1_valid_reg, s1_valid_next;
    item_t s1_item_reg;
    logic  s2_valid_reg, s2_valid_next;
    logic [7:0] s2_rd_reg;
    logic [3:0] s2_mask_reg;
    logic [2:0] s2_code_reg;

    logic   out_ready;
    logic   s2_load;
    logic   s1_go;
    logic   s2_go;
    logic   s_accept;
    logic [7:0] rd_data;
    state_t state;

    assign out_ready = !m_tvalid || m_tready;
    assign s2_go     = s2_valid_reg && out_ready;
    assign s2_load   = !s2_valid_reg || out_ready;
    assign s1_go     = s1_valid_reg && s2_load;
    assign s_tready  = !s1_valid_reg || s2_load;
    assign s_accept  = s_tvalid && s_tready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s_accept)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;

        s2_valid_next = s2_valid_reg;
        if (s1_go)
            s2_valid_next = 1'b1;
        else if (s2_go)
            s2_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
            s1_item_reg <= item_t'(s_tdata[ITEM_W-1:0]);
        if (s1_go)
        begin
            s2_rd_reg   <= rd_data;
            s2_mask_reg <= s1_item_reg.overlap_mask;
            s2_code_reg <= s1_item_reg.pixel_code;
        end
    end

    vwc_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (s1_go),
        .item      (s1_item_reg),
        .read_data (rd_data),
        .state     (state)
    );

    vwc_lookup u_lookup (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s2_go),
        .state     (state),
        .rd_in     (s2_rd_reg),
        .mask_in   (s2_mask_reg),
        .code_in   (s2_code_reg),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

endmodule

/* hw/rtl/vwc_checker.sv */
`include "video_window_controller_regs_unit_assert.svh"

module vwc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // no result can be shown in the cycle after reset
    `VWC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !m_tvalid, "result valid right after reset")

    `VWC_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")

    `VWC_ASSERT(a_win_range, m_tvalid |-> m_tdata[10:8] <= 3'd4, "window number out of range")

    // mono mode only produces black or white
    `VWC_ASSERT(a_mono, m_tvalid && m_tdata[37] |-> (m_tdata[36:34] == 3'd0) || (m_tdata[36:34] == 3'd7), "mono color not 0 or 7")

    // with both sides idle, the three-stage pipe drains and shows no result without an item
    `VWC_ASSERT(a_latency, (!m_tvalid && !s_tvalid) [*3] |=> !m_tvalid, "result without item")

endmodule

bind video_window_controller_regs_unit vwc_checker u_vwc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
